// ===== hdl/tree_path_add_sum_assert.svh =====
// ---------------------------------------------------------------------------
// tree_path_add_sum assertion macros
// Shared concurrent assertion forms for the path add/sum block.
// ---------------------------------------------------------------------------
`ifndef TREE_PATH_ADD_SUM_ASSERT_SVH
`define TREE_PATH_ADD_SUM_ASSERT_SVH

// Same-cycle implication or invariant, masked during reset.
`define TPAS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a property in the next cycle.
`define TPAS_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== hdl/tpas_pkg.sv =====
// ---------------------------------------------------------------------------
// tpas_pkg
// Types and fixed widths shared by the path add/sum block.
// ---------------------------------------------------------------------------
package tpas_pkg;

   localparam int NODE_W = 11;  // node numbers, levels
   localparam int POS_W  = 10;  // stored chain positions
   localparam int RNG_W  = 11;  // segment ranges and bounds
   localparam int SUM_W  = 32;
   localparam int CMD_W  = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SUM  = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0] parent;
      logic [NODE_W-1:0] head;
      logic [NODE_W-1:0] level;
      logic [POS_W-1:0]  pos;
   } node_entry_type;

   typedef struct packed {
      logic [SUM_W-1:0] pend;
      logic [SUM_W-1:0] sum;
   } seg_entry_type;

   typedef struct packed {
      logic             clear;
      logic             start;
      logic             do_add;
      logic [RNG_W-1:0] lo_bound;
      logic [RNG_W-1:0] hi_bound;
      logic [RNG_W-1:0] top;
   } seg_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] sum;
   } seg_rsp_type;

endpackage

// ===== hdl/tpas_ram.sv =====
// ---------------------------------------------------------------------------
// tpas_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ---------------------------------------------------------------------------
module tpas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tpas_seg.sv =====
// ---------------------------------------------------------------------------
// tpas_seg
// Lazy segment tree engine: range add-one or range sum over a RAM of nodes,
// walked depth first with an explicit range stack. Also runs the clear sweep.
// ---------------------------------------------------------------------------
`include "tree_path_add_sum_assert.svh"

module tpas_seg import tpas_pkg::*; #(
   parameter int SEGMENT_NODES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  seg_req_type seg_req,
   output seg_rsp_type seg_rsp
);

   localparam int ADDR_W  = $clog2(SEGMENT_NODES);
   localparam int IDX_W   = ADDR_W + 1;
   localparam int STACK_N = ADDR_W;
   localparam int SP_W    = $clog2(STACK_N);
   localparam int DEP_W   = $clog2(STACK_N + 1);
   localparam logic [IDX_W-1:0]  SEG_LIMIT = IDX_W'(SEGMENT_NODES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SEGMENT_NODES - 1);

   typedef struct packed {
      logic [RNG_W-1:0] lo;
      logic [RNG_W-1:0] hi;
   } span_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_VISIT, S_NODE, S_PUSH_RD, S_PUSH_WR,
      S_DESCEND, S_RETURN, S_FIN_L, S_FIN_R, S_FIN_WR
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [RNG_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [RNG_W-1:0] lb_ff, lb_in, rb_ff, rb_in;
   logic [DEP_W-1:0] depth_ff, depth_in;
   span_type         stack_ff [STACK_N];
   span_type         stack_in [STACK_N];
   logic [SUM_W-1:0] pend_ff, pend_in, acc_ff, acc_in, left_ff, left_in;
   logic             child_ff, child_in, add_ff, add_in, done_ff, done_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   seg_entry_type     ram_wdata, node;
   logic [2*SUM_W-1:0] ram_rdata;

   logic [RNG_W-1:0] mid, pmid, len, len_c;
   logic [DEP_W-1:0] dm1;
   span_type         par;
   logic [IDX_W-1:0] child_idx, left_idx, right_idx;
   logic             idx_ok, child_ok, left_ok, right_ok, disjoint, covered;
   logic [SUM_W-1:0] scaled;

   tpas_ram #(.WIDTH(2 * SUM_W), .DEPTH(SEGMENT_NODES)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign node      = seg_entry_type'(ram_rdata);
   assign mid       = RNG_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign dm1       = depth_ff - DEP_W'(1);
   assign par       = stack_ff[dm1[SP_W-1:0]];
   assign pmid      = RNG_W'(({1'b0, par.lo} + {1'b0, par.hi}) >> 1);
   assign len       = hi_ff - lo_ff + RNG_W'(1);
   assign len_c     = child_ff ? (hi_ff - mid) : (mid - lo_ff + RNG_W'(1));
   assign scaled    = SUM_W'(32'(len_c) * pend_ff);
   assign child_idx = {idx_ff[ADDR_W-1:0], child_ff};
   assign left_idx  = {idx_ff[ADDR_W-1:0], 1'b0};
   assign right_idx = {idx_ff[ADDR_W-1:0], 1'b1};
   assign idx_ok    = idx_ff < SEG_LIMIT;
   assign child_ok  = child_idx < SEG_LIMIT;
   assign left_ok   = left_idx < SEG_LIMIT;
   assign right_ok  = right_idx < SEG_LIMIT;
   assign disjoint  = (lo_ff > rb_ff) || (hi_ff < lb_ff);
   assign covered   = (lb_ff <= lo_ff) && (hi_ff <= rb_ff);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      lb_in     = lb_ff;
      rb_in     = rb_ff;
      depth_in  = depth_ff;
      stack_in  = stack_ff;
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      left_in   = left_ff;
      child_in  = child_ff;
      add_in    = add_ff;
      clr_in    = clr_ff;
      done_in   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[ADDR_W-1:0];
      ram_wdata = '0;
      ram_raddr = idx_ff[ADDR_W-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (seg_req.start) begin
               add_in   = seg_req.do_add;
               lb_in    = seg_req.lo_bound;
               rb_in    = seg_req.hi_bound;
               idx_in   = IDX_W'(1);
               lo_in    = RNG_W'(1);
               hi_in    = seg_req.top;
               depth_in = '0;
               acc_in   = '0;
               state_in = S_VISIT;
            end
         end
         S_VISIT: begin
            state_in = (!idx_ok || disjoint) ? S_RETURN : S_NODE;
         end
         S_NODE: begin
            if (covered) begin
               if (add_ff) begin
                  ram_we         = 1'b1;
                  ram_wdata.pend = node.pend + SUM_W'(1);
                  ram_wdata.sum  = node.sum + SUM_W'(len);
               end else begin
                  acc_in = acc_ff + node.sum;
               end
               state_in = S_RETURN;
            end else begin
               pend_in = node.pend;
               if (node.pend != '0) begin
                  // push: pending goes to the children, this node keeps its sum
                  ram_we        = 1'b1;
                  ram_wdata.sum = node.sum;
                  child_in      = 1'b0;
                  state_in      = S_PUSH_RD;
               end else begin
                  state_in = S_DESCEND;
               end
            end
         end
         S_PUSH_RD: begin
            ram_raddr = child_idx[ADDR_W-1:0];
            if (child_ok) begin
               state_in = S_PUSH_WR;
            end else if (!child_ff) begin
               child_in = 1'b1;
            end else begin
               state_in = S_DESCEND;
            end
         end
         S_PUSH_WR: begin
            ram_we         = 1'b1;
            ram_waddr      = child_idx[ADDR_W-1:0];
            ram_wdata.pend = node.pend + pend_ff;
            ram_wdata.sum  = node.sum + scaled;
            if (!child_ff) begin
               child_in = 1'b1;
               state_in = S_PUSH_RD;
            end else begin
               state_in = S_DESCEND;
            end
         end
         S_DESCEND: begin
            stack_in[depth_ff[SP_W-1:0]] = '{lo: lo_ff, hi: hi_ff};
            depth_in = depth_ff + DEP_W'(1);
            idx_in   = left_idx;
            hi_in    = mid;
            state_in = S_VISIT;
         end
         S_RETURN: begin
            if (depth_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else if (!idx_ff[0]) begin
               // left subtree finished, go to its sibling
               idx_in   = {idx_ff[IDX_W-1:1], 1'b1};
               lo_in    = pmid + RNG_W'(1);
               hi_in    = par.hi;
               state_in = S_VISIT;
            end else begin
               idx_in   = idx_ff >> 1;
               lo_in    = par.lo;
               hi_in    = par.hi;
               depth_in = dm1;
               state_in = add_ff ? S_FIN_L : S_RETURN;
            end
         end
         S_FIN_L: begin
            ram_raddr = left_idx[ADDR_W-1:0];
            state_in  = S_FIN_R;
         end
         S_FIN_R: begin
            left_in   = left_ok ? node.sum : '0;
            ram_raddr = right_idx[ADDR_W-1:0];
            state_in  = S_FIN_WR;
         end
         S_FIN_WR: begin
            ram_we        = 1'b1;
            ram_wdata.sum = left_ff + (right_ok ? node.sum : '0);
            state_in      = S_RETURN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (seg_req.clear) begin
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         depth_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         depth_ff <= depth_in;
         done_ff  <= done_in;
      end
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      lb_ff    <= lb_in;
      rb_ff    <= rb_in;
      stack_ff <= stack_in;
      pend_ff  <= pend_in;
      acc_ff   <= acc_in;
      left_ff  <= left_in;
      child_ff <= child_in;
      add_ff   <= add_in;
   end

   assign seg_rsp.busy = (state_ff != S_IDLE);
   assign seg_rsp.done = done_ff;
   assign seg_rsp.sum  = acc_ff;

   `TPAS_ASSERT(a_depth_bound, clock, reset, depth_ff <= DEP_W'(STACK_N), "range stack overflow")
   `TPAS_ASSERT(a_descend_in_ram, clock, reset, (state_ff == S_DESCEND) |-> idx_ok, "descent from node outside store")
   `TPAS_ASSERT_NEXT(a_done_pulse, clock, reset, seg_rsp.done, !seg_rsp.done, "done longer than one cycle")

endmodule

// ===== hdl/tree_path_add_sum.sv =====
// ---------------------------------------------------------------------------
// tree_path_add_sum: heavy-light path add-one / path sum over a lazy segment tree
// Steps: a load writes its table entry; a path item fetches both ends, climbs chain hops
// and runs segment tree range steps; one item is taken at a time, and a new one only while
// idle; a looping table runs the full MAX_NODES hops
// Reset: node count 2, then a clear sweep over all SEGMENT_NODES entries (also per csr write)
// ---------------------------------------------------------------------------
`include "tree_path_add_sum_assert.svh"

module tree_path_add_sum import tpas_pkg::*; #(
   parameter int MAX_NODES     = 1024,
   parameter int SEGMENT_NODES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [NODE_W-1:0] req_node_a,
   input  logic [NODE_W-1:0] req_node_b,
   input  logic [NODE_W-1:0] req_parent_node,
   input  logic [NODE_W-1:0] req_chain_head,
   input  logic [NODE_W-1:0] req_node_level,
   input  logic [POS_W-1:0]  req_chain_position,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SUM_W-1:0]  rsp_path_sum,
   // node count register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NODE_W-1:0] csr_node_count
);

   localparam int AW    = $clog2(MAX_NODES);
   localparam int HOP_W = $clog2(MAX_NODES + 1);
   // node mod MAX_NODES: quotient estimate by reciprocal, then one correction
   localparam int SLOT_RECIP = (2 ** NODE_W) / MAX_NODES;

   typedef enum logic [4:0] {
      W_IDLE, W_LD_Q, W_LD_WR, W_A_Q, W_A_RD, W_B_Q, W_B_RD, W_B_CAP, W_CHK,
      W_TA_Q, W_TA_RD, W_TB_Q, W_TB_RD, W_CMP, W_SEG, W_NA_Q, W_NA_RD,
      W_NA_CAP, W_FIN, W_FSEG, W_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [NODE_W-1:0] nb_ff, nb_in, raw_ff, raw_in, q_ff, q_in, nc_ff, nc_in;
   node_entry_type    ld_ff, ld_in, ent_a_ff, ent_a_in, ent_b_ff, ent_b_in, ta_ff, ta_in;
   logic [HOP_W-1:0]  hops_ff, hops_in;
   logic [SUM_W-1:0]  total_ff, total_in, rsp_sum_ff, rsp_sum_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [2*NODE_W-1:0] prod;
   logic [31:0]         qm, rdiff, rem;
   logic [AW-1:0]       slot;
   logic                tbl_we;
   logic [$bits(node_entry_type)-1:0] tbl_rdata;
   node_entry_type      tbl_rd, ta_sel, ea_sel, lo_e, hi_e;
   logic [RNG_W-1:0]    seg_l, seg_r;
   logic                swap;
   seg_req_type         seg_req;
   seg_rsp_type         seg_rsp;

   // -- node table: {parent, chain head, level, position} in one word ------
   tpas_ram #(.WIDTH($bits(node_entry_type)), .DEPTH(MAX_NODES)) u_tbl (
      .clock  (clock),
      .wr_en  (tbl_we),
      .wr_addr(slot),
      .wr_data(ld_ff),
      .rd_addr(slot),
      .rd_data(tbl_rdata)
   );

   tpas_seg #(.SEGMENT_NODES(SEGMENT_NODES)) u_seg (
      .clock  (clock),
      .reset  (reset),
      .seg_req(seg_req),
      .seg_rsp(seg_rsp)
   );

   assign tbl_rd = node_entry_type'(tbl_rdata);

   // -- slot reduction: raw_ff -> q_ff (registered) -> slot ------------------
   // Every table access loads raw_ff one state ahead (the _Q states), so q_ff
   // matches raw_ff when the read or write address is used.
   assign prod  = (2 * NODE_W)'(raw_ff) * (2 * NODE_W)'(SLOT_RECIP);
   assign q_in  = prod[2*NODE_W-1:NODE_W];
   assign qm    = 32'(q_ff) * 32'(MAX_NODES);
   assign rdiff = 32'(raw_ff) - qm;
   assign rem   = (rdiff >= 32'(MAX_NODES)) ? (rdiff - 32'(MAX_NODES)) : rdiff;
   assign slot  = rem[AW-1:0];

   assign csr_ready = 1'b1;

   // -- chain walk sequencer -----------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      nb_in        = nb_ff;
      raw_in       = raw_ff;
      ld_in        = ld_ff;
      ent_a_in     = ent_a_ff;
      ent_b_in     = ent_b_ff;
      ta_in        = ta_ff;
      hops_in      = hops_ff;
      total_in     = total_ff;
      nc_in        = nc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      tbl_we       = 1'b0;
      req_ready    = 1'b0;
      swap         = 1'b0;
      ta_sel       = ta_ff;
      ea_sel       = ent_a_ff;
      lo_e         = ent_a_ff;
      hi_e         = ent_b_ff;
      seg_l        = '0;
      seg_r        = '0;
      seg_req.clear  = csr_valid;
      seg_req.start  = 1'b0;
      seg_req.do_add = (cmd_ff == CMD_ADD);
      seg_req.top    = nc_ff - NODE_W'(1);

      unique case (state_ff)
         W_IDLE: begin
            req_ready = !seg_rsp.busy;
            if (req_valid && req_ready) begin
               cmd_in = req_command;
               raw_in = req_node_a;
               nb_in  = req_node_b;
               ld_in  = '{parent: req_parent_node, head: req_chain_head,
                          level: req_node_level, pos: req_chain_position};
               unique case (req_command) inside
                  CMD_LOAD:         state_in = W_LD_Q;
                  CMD_ADD, CMD_SUM: state_in = W_A_Q;
                  default:          state_in = W_IDLE;
               endcase
            end
         end
         W_LD_Q:  state_in = W_LD_WR;
         W_LD_WR: begin
            tbl_we   = 1'b1;
            state_in = W_IDLE;
         end
         // fetch both path ends
         W_A_Q:  state_in = W_A_RD;
         W_A_RD: begin
            raw_in   = nb_ff;
            state_in = W_B_Q;
         end
         W_B_Q: begin
            ent_a_in = tbl_rd;
            state_in = W_B_RD;
         end
         W_B_RD: state_in = W_B_CAP;
         W_B_CAP: begin
            ent_b_in = tbl_rd;
            hops_in  = '0;
            total_in = '0;
            state_in = W_CHK;
         end
         // different chains: climb the end whose chain top is deeper
         W_CHK: begin
            if (ent_a_ff.head != ent_b_ff.head && hops_ff < HOP_W'(MAX_NODES)) begin
               raw_in   = ent_a_ff.head;
               state_in = W_TA_Q;
            end else begin
               state_in = W_FIN;
            end
         end
         W_TA_Q:  state_in = W_TA_RD;
         W_TA_RD: begin
            raw_in   = ent_b_ff.head;
            state_in = W_TB_Q;
         end
         W_TB_Q: begin
            ta_in    = tbl_rd;
            state_in = W_TB_RD;
         end
         W_TB_RD: state_in = W_CMP;
         W_CMP: begin
            // tbl_rd holds the entry of b's chain top here
            swap   = ta_ff.level < tbl_rd.level;
            ta_sel = swap ? tbl_rd : ta_ff;
            ea_sel = swap ? ent_b_ff : ent_a_ff;
            if (swap) begin
               ent_a_in = ent_b_ff;
               ent_b_in = ent_a_ff;
            end
            ta_in  = ta_sel;
            raw_in = ta_sel.parent;
            seg_l  = RNG_W'(ta_sel.pos);
            seg_r  = RNG_W'(ea_sel.pos);
            if (seg_l <= seg_r) begin
               seg_req.start = 1'b1;
               state_in      = W_SEG;
            end else begin
               state_in = W_NA_Q;
            end
         end
         W_SEG: begin
            if (seg_rsp.done) begin
               total_in = total_ff + seg_rsp.sum;
               state_in = W_NA_Q;
            end
         end
         W_NA_Q:  state_in = W_NA_RD;
         W_NA_RD: state_in = W_NA_CAP;
         W_NA_CAP: begin
            ent_a_in = tbl_rd;
            hops_in  = hops_ff + HOP_W'(1);
            state_in = W_CHK;
         end
         // same chain: edges strictly below the shallower end
         W_FIN: begin
            swap  = ent_a_ff.level > ent_b_ff.level;
            lo_e  = swap ? ent_b_ff : ent_a_ff;
            hi_e  = swap ? ent_a_ff : ent_b_ff;
            seg_l = RNG_W'(lo_e.pos) + RNG_W'(1);
            seg_r = RNG_W'(hi_e.pos);
            if (seg_l <= seg_r) begin
               seg_req.start = 1'b1;
               state_in      = W_FSEG;
            end else begin
               state_in = W_OUT;
            end
         end
         W_FSEG: begin
            if (seg_rsp.done) begin
               total_in = total_ff + seg_rsp.sum;
               state_in = W_OUT;
            end
         end
         W_OUT: begin
            if (cmd_ff != CMD_SUM) begin
               state_in = W_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = total_ff;
               state_in     = W_IDLE;
            end
         end
         default: state_in = W_IDLE;
      endcase

      seg_req.lo_bound = seg_l;
      seg_req.hi_bound = seg_r;

      // node count write saturates into 2 .. MAX_NODES
      if (csr_valid) begin
         if (csr_node_count < NODE_W'(2)) begin
            nc_in = NODE_W'(2);
         end else if (32'(csr_node_count) > 32'(MAX_NODES)) begin
            nc_in = NODE_W'(MAX_NODES);
         end else begin
            nc_in = csr_node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         nc_ff        <= NODE_W'(2);
         rsp_valid_ff <= 1'b0;
         hops_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         nc_ff        <= nc_in;
         rsp_valid_ff <= rsp_valid_in;
         hops_ff      <= hops_in;
      end
      cmd_ff     <= cmd_in;
      nb_ff      <= nb_in;
      raw_ff     <= raw_in;
      q_ff       <= q_in;
      ld_ff      <= ld_in;
      ent_a_ff   <= ent_a_in;
      ent_b_ff   <= ent_b_in;
      ta_ff      <= ta_in;
      total_ff   <= total_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_path_sum = rsp_sum_ff;

   `TPAS_ASSERT(a_ready_seg_idle, clock, reset, req_ready |-> !seg_rsp.busy, "item taken while segment engine busy")
   `TPAS_ASSERT(a_start_state, clock, reset, seg_req.start |-> (state_ff == W_CMP || state_ff == W_FIN), "segment start outside range step")
   `TPAS_ASSERT(a_hop_bound, clock, reset, hops_ff <= HOP_W'(MAX_NODES), "chain hop count past limit")

endmodule
